[design/msdlp_pkg.sv]
`default_nettype none
package msdlp_pkg;

  localparam int TIME_W = 34;
  localparam int ADDR_W = 32;
  localparam int HALF_W = 56;
  localparam int MSG_W  = 112;
  localparam int LEN_W  = 5;
  localparam int DF_W   = 5;

  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [LEN_W-1:0] LEN_MAX    = 5'd31;
  localparam logic [LEN_W-1:0] LEN_ADDR   = 5'd6;
  localparam logic [LEN_W-1:0] LEN_TIME_A = 5'd9;
  localparam logic [LEN_W-1:0] LEN_TIME_B = 5'd10;
  localparam logic [LEN_W-1:0] LEN_SHORT  = 5'd14;
  localparam logic [LEN_W-1:0] LEN_LONG   = 5'd28;
  // wrapped forms carry a leading star and a trailing semicolon
  localparam logic [LEN_W-1:0] LEN_SHORT_W = 5'd16;
  localparam logic [LEN_W-1:0] LEN_LONG_W  = 5'd30;
  localparam logic [LEN_W-1:0] LEN_WRAP_MIN = 5'd2;

  localparam logic [ADDR_W-1:0] NO_ADDRESS = 32'hff00_0000;
  localparam logic [TIME_W-1:0] ACC_MAX    = '1;

  localparam logic [31:0] SHORT_MASK_RST = 32'd2097;
  localparam logic [31:0] LONG_MASK_RST  = 32'd20905984;

  localparam logic REG_SHORT_MASK = 1'b0;
  localparam logic REG_LONG_MASK  = 1'b1;

  typedef struct packed {
    logic inhex_prev;  // hex from index 1 through previous char
    logic inhex;       // hex from index 1 through current char
    logic semi;        // last char is a semicolon
    logic star;        // first char is a star
    logic hex;         // all chars hex
    logic dec;         // all chars decimal
  } tok_flags_t;

  localparam tok_flags_t TOK_FLAGS_RST = '{
    inhex_prev: 1'b1, inhex: 1'b1, semi: 1'b0, star: 1'b0, hex: 1'b1, dec: 1'b1
  };

  typedef struct packed {
    logic lng;
    logic msg;
    logic addr;
    logic tim;
  } found_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_value(input logic [7:0] c);
    hex_digit_t h;
    h.ok    = 1'b1;
    h.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.value = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.value = 4'(c - 8'h57);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage
`default_nettype wire

[design/mode_s_dump_line_parser_core.sv]
// a result appears in the cycle after its end-of-line word is accepted
// throughput: one word per cycle; each word goes through combinational logic
// straight into the token state and result registers
// a result held by result_ready low stalls every incoming word
// rst (synchronous, active high) clears the token, the nibble window, the line
// flags and the result valid, and loads the format masks with their defaults
`default_nettype none
module mode_s_dump_line_parser_core
  import msdlp_pkg::*;
#(
  parameter int MAX_MSG_NIBBLES = 28
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  input  wire logic               item_valid,
  output logic                    item_ready,
  input  wire logic [7:0]         char_in,
  input  wire logic               end_of_line,
  output logic                    result_valid,
  input  wire logic               result_ready,
  output logic                    msg_valid,
  output logic                    long_msg,
  output logic      [DF_W-1:0]    df_code,
  output logic      [HALF_W-1:0]  msg_first_half,
  output logic      [HALF_W-1:0]  msg_second_half,
  output logic      [TIME_W-1:0]  stamp_seconds,
  output logic      [ADDR_W-1:0]  icao_address
);

  localparam int   WIN_W   = 4 * MAX_MSG_NIBBLES;
  localparam logic LONG_OK = (MAX_MSG_NIBBLES >= 28);

  logic [31:0]        short_mask;
  logic [31:0]        long_mask;
  logic [LEN_W-1:0]   tok_len;
  tok_flags_t         tok_flags;
  logic [WIN_W-1:0]   win;
  logic [TIME_W-1:0]  acc;
  logic [TIME_W-1:0]  cap_time;
  logic [ADDR_W-1:0]  cap_addr;
  found_t             found;
  logic [MSG_W-1:0]   msg_store;

  logic [LEN_W-1:0]   tok_len_next;
  tok_flags_t         tok_flags_next;
  logic [WIN_W-1:0]   win_next;
  logic [TIME_W-1:0]  acc_next;
  logic [TIME_W-1:0]  cap_time_next;
  logic [ADDR_W-1:0]  cap_addr_next;
  found_t             found_next;
  logic [MSG_W-1:0]   msg_store_next;

  logic               accept;
  logic               take;
  logic               close;
  logic               eol;
  hex_digit_t         hx;
  logic               is_dec;
  tok_flags_t         f;
  logic [TIME_W+3:0]  acc_mul;
  logic [MSG_W-1:0]   win_ext;
  logic               is_time;
  logic               is_addr;
  logic               star_ok;
  logic               n14;
  logic               n28;
  logic               is_msg;
  found_t             found_cl;
  logic [MSG_W-1:0]   store_cl;
  logic [TIME_W-1:0]  time_cl;
  logic [ADDR_W-1:0]  addr_cl;
  logic [DF_W-1:0]    df_cl;

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_LONG_MASK) ? long_mask : short_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      short_mask <= SHORT_MASK_RST;
      long_mask  <= LONG_MASK_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_SHORT_MASK: short_mask <= pwdata;
        REG_LONG_MASK:  long_mask  <= pwdata;
        default: ;
      endcase
    end
  end

  assign item_ready = !result_valid || result_ready;
  assign accept     = item_valid && item_ready;
  assign eol        = accept && end_of_line;
  assign take       = accept && !end_of_line && (char_in != CH_COLON);
  assign close      = accept && (end_of_line || (char_in == CH_COLON));

  assign hx      = hex_value(char_in);
  assign is_dec  = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
  assign win_ext = MSG_W'(win);

  // classify the current token as it closes
  always_comb begin
    is_time = !found.tim && ((tok_len == LEN_TIME_A) || (tok_len == LEN_TIME_B))
              && tok_flags.dec;
    is_addr = !is_time && !found.addr && (tok_len == LEN_ADDR) && tok_flags.hex;
    star_ok = (tok_len > LEN_WRAP_MIN) && tok_flags.star && tok_flags.semi
              && tok_flags.inhex_prev;
    n14     = (star_ok && tok_len == LEN_SHORT_W) || (tok_flags.hex && tok_len == LEN_SHORT);
    n28     = LONG_OK && ((star_ok && tok_len == LEN_LONG_W)
              || (tok_flags.hex && tok_len == LEN_LONG));
    is_msg  = close && !is_time && !is_addr && !found.msg && (n14 || n28);

    found_cl = found;
    time_cl  = cap_time;
    addr_cl  = cap_addr;
    store_cl = msg_store;
    if (close && is_time) begin
      found_cl.tim = 1'b1;
      time_cl      = acc;
    end
    if (close && is_addr) begin
      found_cl.addr = 1'b1;
      addr_cl       = ADDR_W'(win[23:0]);
    end
    if (is_msg) begin
      found_cl.msg = 1'b1;
      found_cl.lng = n28;
      // short message goes to the upper half, lower half reads as zero
      store_cl = n28 ? win_ext : {win_ext[HALF_W-1:0], {HALF_W{1'b0}}};
    end
    df_cl = store_cl[MSG_W-1 -: DF_W];
  end

  // per-character token tracking
  always_comb begin
    f = tok_flags;
    if (!is_dec) f.dec = 1'b0;
    if (!hx.ok)  f.hex = 1'b0;
    if (tok_len == '0) begin
      f.star = (char_in == CH_STAR);
    end else begin
      f.inhex_prev = f.inhex;
      if (!hx.ok) f.inhex = 1'b0;
    end
    f.semi  = (char_in == CH_SEMI);
    acc_mul = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + (TIME_W+4)'(char_in[3:0]);

    tok_len_next   = tok_len;
    tok_flags_next = tok_flags;
    acc_next       = acc;
    win_next       = win;
    found_next     = found_cl;
    cap_time_next  = time_cl;
    cap_addr_next  = addr_cl;
    msg_store_next = store_cl;

    if (take) begin
      tok_flags_next = f;
      if (f.dec && is_dec) begin
        acc_next = (acc_mul > (TIME_W+4)'(ACC_MAX)) ? ACC_MAX : acc_mul[TIME_W-1:0];
      end
      if (hx.ok) begin
        win_next = {win[WIN_W-5:0], hx.value};
      end
      if (tok_len != LEN_MAX) begin
        tok_len_next = tok_len + 1'b1;
      end
    end
    if (close) begin
      tok_len_next   = '0;
      tok_flags_next = TOK_FLAGS_RST;
      acc_next       = '0;
    end
    if (eol) begin
      found_next    = '0;
      cap_time_next = '0;
      cap_addr_next = NO_ADDRESS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_len   <= '0;
      tok_flags <= TOK_FLAGS_RST;
      acc       <= '0;
      win       <= '0;
      found     <= '0;
      cap_time  <= '0;
      cap_addr  <= NO_ADDRESS;
    end else begin
      tok_len   <= tok_len_next;
      tok_flags <= tok_flags_next;
      acc       <= acc_next;
      win       <= win_next;
      found     <= found_next;
      cap_time  <= cap_time_next;
      cap_addr  <= cap_addr_next;
    end
  end

  always_ff @(posedge clk) begin
    msg_store <= msg_store_next;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (eol) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eol) begin
      stamp_seconds <= time_cl;
      icao_address  <= addr_cl;
      if (found_cl.msg) begin
        long_msg        <= found_cl.lng;
        df_code         <= df_cl;
        msg_first_half  <= store_cl[MSG_W-1:HALF_W];
        msg_second_half <= found_cl.lng ? store_cl[HALF_W-1:0] : '0;
        msg_valid       <= found_cl.lng ? long_mask[df_cl] : short_mask[df_cl];
      end else begin
        long_msg        <= 1'b0;
        df_code         <= '0;
        msg_first_half  <= '0;
        msg_second_half <= '0;
        msg_valid       <= 1'b0;
      end
    end
  end

  a_result_from_eol: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(item_valid && item_ready && end_of_line))
    else $error("result without end of line");

  a_df_matches: assert property (@(posedge clk) disable iff (rst)
    result_valid && msg_valid |-> df_code == msg_first_half[HALF_W-1 -: DF_W])
    else $error("df code does not match message byte 0");

  a_short_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !long_msg |-> msg_second_half == '0)
    else $error("short message has nonzero second half");

  a_long_allowed: assert property (@(posedge clk) disable iff (rst)
    result_valid && long_msg |-> LONG_OK)
    else $error("long message wider than window");

endmodule
`default_nettype wire
